// ===== hdl/msp_pkg.sv =====
`default_nettype none
package msp_pkg;

	// Sizes of the stack store and the node pool.
	localparam int NUM_STACKS = 8;
	localparam int POOL_DEPTH = 64;
	localparam int DATA_WIDTH = 32;

	// Field widths on the stream ports.
	localparam int CMD_W = 2;
	localparam int SID_W = 4;
	localparam int VAL_W = 32;
	localparam int STATUS_W = 2;
	localparam int OUT_W = 32;
	localparam int S_TDATA_W = ((SID_W + VAL_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// Node pointers carry a null code outside the pool.
	localparam int PTR_W = 7;
	localparam logic [PTR_W-1:0] NIL = {PTR_W{1'b1}};
	localparam int AW = $clog2(POOL_DEPTH);
	localparam int IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int CNT_W = $clog2(NUM_STACKS + 1);
	localparam int K_W = $clog2(POOL_DEPTH);
	localparam int CMP_W = 8;

	// Queue between the front and back parts.
	localparam int QDEPTH = 2;
	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	// Command codes on the input tuser.
	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SHOW = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_SHOW
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK,
		STS_NOT_FOUND,
		STS_EMPTY,
		STS_FULL
	} status_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_DECODE,
		BS_PUSH,
		BS_POP,
		BS_WALK
	} back_state_t;

	// One classified command as it sits in the queue.
	typedef struct packed {
		op_t              op;
		logic [SID_W-1:0] sid;
		logic [VAL_W-1:0] value;
	} item_t;

	// A pointer names a pool node only below the pool depth.
	function automatic logic valid_node(logic [PTR_W-1:0] p);
		return p < PTR_W'(POOL_DEPTH);
	endfunction

	// Link held by a node that was never rewritten since reset.
	function automatic logic [PTR_W-1:0] link_init(logic [AW-1:0] a);
		int n;
		n = int'(a) + 1;
		if (n < POOL_DEPTH) begin
			return PTR_W'(n);
		end
		return NIL;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/multi_stack_shared_pool.sv =====
// Sequence: the back part runs one queued command at a time. An error result is loaded in
// the decode state, a push or pop result in the push or pop state, set by the back sequencer
// and the registered link/value memory reads; a display shows one node per cycle unless m_tready stalls.
// Reset: arst_n clears all stacks, the stack count and the queue at once; per-node valid
// bits restore the initial free list, so no clearing pass is needed after reset.
`default_nettype none
module multi_stack_shared_pool (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// Fields from bit 0: stack_id [3:0], value [35:4], zero pad [39:36].
	input  wire logic [msp_pkg::S_TDATA_W-1:0] s_tdata,
	// Fields from bit 0: cmd [1:0].
	input  wire logic [msp_pkg::CMD_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// Fields from bit 0: data_out [31:0].
	output logic [msp_pkg::M_TDATA_W-1:0]      m_tdata,
	// Fields from bit 0: status [1:0].
	output logic [msp_pkg::STATUS_W-1:0]       m_tuser,
	output logic                               m_tlast
);
	import msp_pkg::*;

	item_t q_item;
	logic  q_rd;
	logic  q_empty;

	// Front part: accept and classify commands into the queue.
	msp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_item   (q_item),
		.q_rd     (q_rd),
		.q_empty  (q_empty)
	);

	// Back part: run commands against the stacks and the node pool.
	msp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_item   (q_item),
		.q_empty  (q_empty),
		.q_rd     (q_rd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== hdl/msp_queue.sv =====
`default_nettype none
module msp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire msp_pkg::item_t wr_item,
	output logic                full,
	input  wire logic           rd_en,
	output msp_pkg::item_t      rd_item,
	output logic                empty
);
	import msp_pkg::*;

	item_t          slot_q [QDEPTH];
	logic [QAW:0]   wptr_q;
	logic [QAW:0]   rptr_q;

	// Pointers carry one extra bit to tell full from empty.
	assign empty = (wptr_q == rptr_q);
	assign full = (wptr_q[QAW-1:0] == rptr_q[QAW-1:0]) && (wptr_q[QAW] != rptr_q[QAW]);
	assign rd_item = slot_q[rptr_q[QAW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (wr_en && !full) begin
				wptr_q <= wptr_q + (QAW+1)'(1);
			end
			if (rd_en && !empty) begin
				rptr_q <= rptr_q + (QAW+1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			slot_q[wptr_q[QAW-1:0]] <= wr_item;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/msp_front.sv =====
`default_nettype none
module msp_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [msp_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [msp_pkg::CMD_W-1:0]     s_tuser,
	output msp_pkg::item_t                     q_item,
	input  wire logic                          q_rd,
	output logic                               q_empty
);
	import msp_pkg::*;

	logic  q_full;
	logic  q_wr;
	item_t item;

	// Decode the command; the reserved code is dropped at the door.
	always_comb begin
		item.sid = s_tdata[SID_W-1:0];
		item.value = s_tdata[SID_W+VAL_W-1:SID_W];
		case (s_tuser)
			CMD_PUSH: item.op = OP_PUSH;
			CMD_POP:  item.op = OP_POP;
			CMD_SHOW: item.op = OP_SHOW;
			default:  item.op = OP_PUSH;
		endcase
	end

	assign s_tready = !q_full;
	assign q_wr = s_tvalid && s_tready && (s_tuser != CMD_RSVD);

	msp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_item (item),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_item (q_item),
		.empty   (q_empty)
	);

endmodule
`default_nettype wire

// ===== hdl/msp_back.sv =====
`default_nettype none
module msp_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire msp_pkg::item_t                q_item,
	input  wire logic                          q_empty,
	output logic                               q_rd,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [msp_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic [msp_pkg::STATUS_W-1:0]       m_tuser,
	output logic                               m_tlast
);
	import msp_pkg::*;

	back_state_t           state_q;
	back_state_t           state_d;

	item_t                 cur_q;
	logic [PTR_W-1:0]      node_q;
	logic [K_W-1:0]        k_q;
	logic                  create_q;
	logic [PTR_W-1:0]      free_head_q;
	logic [CNT_W-1:0]      created_q;
	logic [PTR_W-1:0]      stack_top_q [NUM_STACKS];

	logic [PTR_W-1:0]      link_mem [POOL_DEPTH];
	logic [POOL_DEPTH-1:0] link_vld_q;
	logic [DATA_WIDTH-1:0] val_mem [POOL_DEPTH];
	logic [PTR_W-1:0]      link_rd_q;
	logic                  link_rd_vld_q;
	logic [AW-1:0]         link_rd_addr_q;
	logic [DATA_WIDTH-1:0] val_rd_q;

	logic                  out_vld_q;
	status_t               out_status_q;
	logic [OUT_W-1:0]      out_data_q;
	logic                  out_last_q;

	logic [IDX_W-1:0]      sidx;
	logic [PTR_W-1:0]      top;
	logic                  exists;
	logic                  create;
	logic                  push_err;
	logic                  read_err;
	logic                  out_free;
	logic [PTR_W-1:0]      link_next;
	logic                  walk_fin;
	logic [OUT_W-1:0]      val_out;

	// Control from the sequencer.
	logic                  rd_en;
	logic                  val_rd_en;
	logic [PTR_W-1:0]      rd_addr;
	logic                  val_wr_en;
	logic                  link_wr_en;
	logic [PTR_W-1:0]      link_wr_addr;
	logic [PTR_W-1:0]      link_wr_data;
	logic                  top_wr_en;
	logic [PTR_W-1:0]      top_wr_data;
	logic                  free_wr_en;
	logic [PTR_W-1:0]      free_wr_data;
	logic                  created_inc;
	logic                  node_ld;
	logic [PTR_W-1:0]      node_d;
	logic                  k_clr;
	logic                  k_inc;
	logic                  create_ld;
	logic                  out_ld;
	status_t               out_status;
	logic [OUT_W-1:0]      out_data;
	logic                  out_last;

	// Classify the current command against the stack state.
	always_comb begin
		sidx = IDX_W'(cur_q.sid - SID_W'(1));
		top = stack_top_q[sidx];
		exists = (cur_q.sid != '0) && (CMP_W'(cur_q.sid) <= CMP_W'(created_q));
		create = !exists && (CMP_W'(cur_q.sid) == CMP_W'(created_q) + CMP_W'(1))
			&& (CMP_W'(created_q) < CMP_W'(NUM_STACKS));
		push_err = (!exists && !create) || !valid_node(free_head_q);
		read_err = !exists || !valid_node(top);
	end

	// A node link that was never written reads as its place in the initial free list.
	assign link_next = link_rd_vld_q ? link_rd_q : link_init(link_rd_addr_q);
	assign walk_fin = !valid_node(link_next) || (k_q == K_W'(POOL_DEPTH - 1));
	assign val_out = OUT_W'($signed(val_rd_q));
	assign out_free = !out_vld_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (!q_empty) begin
					state_d = BS_DECODE;
				end
			end
			BS_DECODE: begin
				if (cur_q.op == OP_PUSH) begin
					if (!push_err) begin
						state_d = BS_PUSH;
					end else if (out_free) begin
						state_d = BS_IDLE;
					end
				end else begin
					if (!read_err) begin
						state_d = (cur_q.op == OP_POP) ? BS_POP : BS_WALK;
					end else if (out_free) begin
						state_d = BS_IDLE;
					end
				end
			end
			BS_PUSH, BS_POP: begin
				if (out_free) begin
					state_d = BS_IDLE;
				end
			end
			BS_WALK: begin
				if (out_free && walk_fin) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		q_rd = 1'b0;
		rd_en = 1'b0;
		val_rd_en = 1'b0;
		rd_addr = node_q;
		val_wr_en = 1'b0;
		link_wr_en = 1'b0;
		link_wr_addr = node_q;
		link_wr_data = top;
		top_wr_en = 1'b0;
		top_wr_data = node_q;
		free_wr_en = 1'b0;
		free_wr_data = link_next;
		created_inc = 1'b0;
		node_ld = 1'b0;
		node_d = top;
		k_clr = 1'b0;
		k_inc = 1'b0;
		create_ld = 1'b0;
		out_ld = 1'b0;
		out_status = STS_OK;
		out_data = '0;
		out_last = 1'b1;
		case (state_q)
			BS_IDLE: begin
				q_rd = !q_empty;
			end
			BS_DECODE: begin
				if (cur_q.op == OP_PUSH) begin
					if (push_err) begin
						out_ld = out_free;
						out_status = (!exists && !create) ? STS_NOT_FOUND : STS_FULL;
					end else begin
						rd_en = 1'b1;
						rd_addr = free_head_q;
						val_wr_en = 1'b1;
						node_ld = 1'b1;
						node_d = free_head_q;
						create_ld = 1'b1;
					end
				end else begin
					if (read_err) begin
						out_ld = out_free;
						out_status = !exists ? STS_NOT_FOUND : STS_EMPTY;
					end else begin
						rd_en = 1'b1;
						val_rd_en = 1'b1;
						rd_addr = top;
						node_ld = 1'b1;
						node_d = top;
						k_clr = 1'b1;
					end
				end
			end
			BS_PUSH: begin
				if (out_free) begin
					out_ld = 1'b1;
					free_wr_en = 1'b1;
					free_wr_data = link_next;
					link_wr_en = 1'b1;
					link_wr_addr = node_q;
					link_wr_data = top;
					top_wr_en = 1'b1;
					top_wr_data = node_q;
					created_inc = create_q;
				end
			end
			BS_POP: begin
				if (out_free) begin
					out_ld = 1'b1;
					out_data = val_out;
					top_wr_en = 1'b1;
					top_wr_data = link_next;
					link_wr_en = 1'b1;
					link_wr_addr = node_q;
					link_wr_data = free_head_q;
					free_wr_en = 1'b1;
					free_wr_data = node_q;
				end
			end
			BS_WALK: begin
				if (out_free) begin
					out_ld = 1'b1;
					out_data = val_out;
					out_last = walk_fin;
					if (!walk_fin) begin
						rd_en = 1'b1;
						val_rd_en = 1'b1;
						rd_addr = link_next;
						node_ld = 1'b1;
						node_d = link_next;
						k_inc = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control state and the stack and free-list heads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			free_head_q <= '0;
			created_q <= '0;
			link_vld_q <= '0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < NUM_STACKS; i++) begin
				stack_top_q[i] <= NIL;
			end
		end else begin
			state_q <= state_d;
			if (free_wr_en) begin
				free_head_q <= free_wr_data;
			end
			if (created_inc) begin
				created_q <= created_q + CNT_W'(1);
			end
			if (top_wr_en) begin
				stack_top_q[sidx] <= top_wr_data;
			end
			if (link_wr_en) begin
				link_vld_q[link_wr_addr[AW-1:0]] <= 1'b1;
			end
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Working registers and the result payload.
	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_item;
		end
		if (node_ld) begin
			node_q <= node_d;
		end
		if (k_clr) begin
			k_q <= '0;
		end else if (k_inc) begin
			k_q <= k_q + K_W'(1);
		end
		if (create_ld) begin
			create_q <= create;
		end
		if (out_ld) begin
			out_status_q <= out_status;
			out_data_q <= out_data;
			out_last_q <= out_last;
		end
	end

	// Link memory with registered read.
	always_ff @(posedge clk) begin
		if (link_wr_en) begin
			link_mem[link_wr_addr[AW-1:0]] <= link_wr_data;
		end
		if (rd_en) begin
			link_rd_q <= link_mem[rd_addr[AW-1:0]];
			link_rd_vld_q <= link_vld_q[rd_addr[AW-1:0]];
			link_rd_addr_q <= rd_addr[AW-1:0];
		end
	end

	// Value memory with registered read.
	always_ff @(posedge clk) begin
		if (val_wr_en) begin
			val_mem[rd_addr[AW-1:0]] <= DATA_WIDTH'(cur_q.value);
		end
		if (val_rd_en) begin
			val_rd_q <= val_mem[rd_addr[AW-1:0]];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = M_TDATA_W'(out_data_q);
	assign m_tuser = out_status_q;
	assign m_tlast = out_last_q;

endmodule
`default_nettype wire
